### src/bfws_pkg.sv
// ----------------------------------------------------------------------------
// bfws_pkg: shared types and constants for the best-fit worker selector.
// Holds result status codes, command codes and the cell handoff struct.
// ----------------------------------------------------------------------------
package bfws_pkg;

    localparam int AMT_W = 16;
    localparam int SEQ_W = 32;
    localparam int WGT_W = 8;
    localparam int LEFT_W = 26;
    localparam int SUM_W = 48;
    localparam int NUM_FIELDS = 4;

    localparam logic [1:0] ST_PLACED = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_NOHEALTHY = 2'd2;
    localparam logic [1:0] ST_LOADED = 2'd3;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PLACE = 1'b1;

    typedef struct packed {
        logic             found;
        logic             saw_healthy;
        logic [7:0]       best;
        logic [SUM_W-1:0] best_sum;
        logic [SEQ_W-1:0] best_seq;
    } bfws_token_t;

endpackage

### src/bfws_cell.sv
// ----------------------------------------------------------------------------
// bfws_cell: one worker entry of the selection chain.
// Stores one worker's state, scores it against the demand and passes the best
// candidate so far to its neighbor, one cell per cycle.
// ----------------------------------------------------------------------------
module bfws_cell
    import bfws_pkg::*;
#(
    parameter int NUM_RESOURCES = 4,
    parameter int INDEX = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               load_en,
    input  logic                               healthy_in,
    input  logic [SEQ_W-1:0]                   seq_in,
    input  logic [NUM_RESOURCES-1:0][AMT_W-1:0] amount,
    input  logic [NUM_RESOURCES-1:0][WGT_W-1:0] weight,
    input  logic                               eligible,
    input  logic                               tok_valid,
    input  bfws_token_t                        tok_in,
    output logic                               tok_valid_out,
    output bfws_token_t                        tok_out,
    input  logic                               commit_en
);

    logic                                present_reg;
    logic                                healthy_reg;
    logic [SEQ_W-1:0]                    seq_reg;
    logic [NUM_RESOURCES-1:0][AMT_W-1:0] free_reg;
    logic                                tok_valid_reg;
    bfws_token_t                         tok_reg;
    bfws_token_t                         tok_next;
    logic                                fits;
    logic [SUM_W-1:0]                    sum;
    logic [AMT_W-1:0]                    left;

    always_comb begin
        fits = 1'b1;
        sum = '0;
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            if (free_reg[r] < amount[r]) begin
                fits = 1'b0;
            end
            left = free_reg[r] - amount[r];
            sum = sum + SUM_W'(left * weight[r]);
        end
        tok_next = tok_in;
        if (present_reg && healthy_reg) begin
            tok_next.saw_healthy = 1'b1;
            if (eligible && fits && (!tok_in.found || sum < tok_in.best_sum)) begin
                tok_next.found = 1'b1;
                tok_next.best = 8'(INDEX);
                tok_next.best_sum = sum;
                tok_next.best_seq = seq_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
            healthy_reg <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else begin
            tok_valid_reg <= tok_valid;
            if (load_en) begin
                present_reg <= 1'b1;
                healthy_reg <= healthy_in;
            end
        end
        tok_reg <= tok_next;
        if (load_en) begin
            seq_reg <= seq_in;
            free_reg <= amount;
        end else if (commit_en) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
                free_reg[r] <= free_reg[r] - amount[r];
            end
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out = tok_reg;

endmodule

### src/best_fit_worker_selector.sv
// ----------------------------------------------------------------------------
// best_fit_worker_selector: best-fit placement over a table of workers.
// Top level with the input/output streams, weight registers and the chain.
// ----------------------------------------------------------------------------
// Usage: the s_ stream carries load and place transactions; each produces one
// m_ transaction. A load writes one worker entry and returns status 3 from
// the busy state registered on acceptance. A place sends a token through
// the start register and a chain of NUM_WORKERS cells, one cell per cycle;
// the result is registered as the token leaves the last cell, and the
// chosen worker's resources are debited in the cycle the result is
// registered.
// One transaction is in flight at a time; a new one is accepted once the
// previous result has been taken or as it is taken.
// Weights are written on the cfg channel (index 0 to 3); the user must write
// them only while idle, as the block itself does not enforce it.
// Synchronous active-low reset clears present/healthy bits, sets all weights
// to one and empties the output register. If the receiver stalls, the result
// holds on m_tdata and no new transaction is accepted.
// ----------------------------------------------------------------------------
module best_fit_worker_selector
    import bfws_pkg::*;
#(
    parameter int NUM_WORKERS = 16,
    parameter int NUM_RESOURCES = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, worker_id, amount_0..3, healthy_in, seq_in, eligible_mask, zero fill
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, chosen_worker, seq_out, leftover_weight
    output logic [63:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data
);

    localparam int NW = NUM_WORKERS;
    localparam int RW = (NUM_RESOURCES < NUM_FIELDS) ? NUM_RESOURCES : NUM_FIELDS;

    logic [NUM_FIELDS-1:0][WGT_W-1:0]   weight_reg;
    logic                               busy_reg;
    logic                               cmd_reg;
    logic [NUM_RESOURCES-1:0][AMT_W-1:0] amt_reg;
    logic [15:0]                        mask_reg;
    logic                               start_reg;
    logic                               m_valid_reg;
    logic [63:0]                        m_data_reg;
    logic [NUM_RESOURCES-1:0][WGT_W-1:0] wgt;
    logic [NW:0]                        tv;
    bfws_token_t                        tk [NW+1];
    logic [NW-1:0]                      commit;
    logic                               accept;
    logic [3:0]                         wid;
    logic [LEFT_W-1:0]                  left_sat;
    // Loads write cells straight from the input, so amounts come from s_tdata then.
    logic [NUM_RESOURCES-1:0][AMT_W-1:0] amt_in;
    logic [NUM_RESOURCES-1:0][AMT_W-1:0] cell_amt;

    assign accept = s_tvalid && s_tready;
    assign s_tready = !busy_reg && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign wid = s_tdata[4:1];

    always_comb begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            amt_in[r] = (r < RW) ? s_tdata[5 + AMT_W*(r % NUM_FIELDS) +: AMT_W] : '0;
        end
    end

    assign cell_amt = accept ? amt_in : amt_reg;

    always_comb begin
        for (int r = 0; r < NUM_RESOURCES; r++) begin
            wgt[r] = (r < RW) ? weight_reg[r % NUM_FIELDS] : '0;
        end
    end

    assign tv[0] = start_reg;
    always_comb begin
        tk[0] = '0;
    end

    genvar g;
    generate
        for (g = 0; g < NW; g++) begin : g_cell
            logic elig;
            assign elig = (g < 16) ? mask_reg[g % 16] : 1'b0;
            assign commit[g] = tv[NW] && tk[NW].found && (tk[NW].best == 8'(g));
            bfws_cell #(.NUM_RESOURCES(NUM_RESOURCES), .INDEX(g)) u_cell (
                .aclk(aclk), .aresetn(aresetn),
                .load_en(accept && s_tdata[0] == CMD_LOAD && 32'(wid) == g),
                .healthy_in(s_tdata[69]), .seq_in(s_tdata[101:70]),
                .amount(cell_amt), .weight(wgt), .eligible(elig),
                .tok_valid(tv[g]), .tok_in(tk[g]),
                .tok_valid_out(tv[g+1]), .tok_out(tk[g+1]),
                .commit_en(commit[g])
            );
        end
    endgenerate

    assign left_sat = (tk[NW].best_sum > SUM_W'({LEFT_W{1'b1}}))
        ? {LEFT_W{1'b1}} : tk[NW].best_sum[LEFT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_FIELDS; r++) weight_reg[r] <= 8'd1;
            busy_reg <= 1'b0;
            start_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) weight_reg[cfg_index] <= cfg_data;
            start_reg <= 1'b0;
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (accept) begin
                busy_reg <= 1'b1;
                cmd_reg <= s_tdata[0];
                mask_reg <= s_tdata[117:102];
                start_reg <= (s_tdata[0] == CMD_PLACE);
            end else if (busy_reg && cmd_reg == CMD_LOAD) begin
                busy_reg <= 1'b0;
                m_valid_reg <= 1'b1;
                m_data_reg <= {38'd0, 24'd0, ST_LOADED};
            end else if (tv[NW]) begin
                busy_reg <= 1'b0;
                m_valid_reg <= 1'b1;
                if (tk[NW].found) begin
                    m_data_reg <= {left_sat, tk[NW].best_seq, tk[NW].best[3:0], ST_PLACED};
                end else begin
                    m_data_reg <= {62'd0, tk[NW].saw_healthy ? ST_NOFIT : ST_NOHEALTHY};
                end
            end
        end
        if (accept) amt_reg <= amt_in;
    end

endmodule

### src/bfws_checker.sv
// ----------------------------------------------------------------------------
// bfws_checker: port-level checks for the best-fit worker selector.
// Watches handshakes and result encoding on the top-level ports.
// ----------------------------------------------------------------------------
module bfws_checker
    import bfws_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_accept_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input accepted while result stalled");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_PLACED |-> m_tdata[63:2] == '0)
        else $error("nonzero fields on unplaced result");

    a_one_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted in flight");

endmodule

bind best_fit_worker_selector bfws_checker u_bfws_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### tb/tb_best_fit_worker_selector.sv
// ----------------------------------------------------------------------------
// tb_best_fit_worker_selector: self-checking testbench for the worker selector.
// Drives load and place transactions with random idling on both streams, keeps
// its own copy of the worker table and weights, and compares every result.
// ----------------------------------------------------------------------------
module tb_best_fit_worker_selector;
    import bfws_pkg::*;

    localparam int NW = 16;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [25:0] leftover;
        logic [31:0] seq;
        logic [3:0]  worker;
        logic [1:0]  status;
    } placement_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [7:0]   cfg_data = '0;

    logic [7:0]   weight [4];
    logic [15:0]  free_amt [NW][4];
    logic         present [NW];
    logic         healthy [NW];
    logic [31:0]  notify [NW];
    placement_t   expected_q [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_off = 0;
    int  quiet_cycles = 0;
    bit  failed = 1'b0;

    best_fit_worker_selector dut (.*);

    always #5 aclk = ~aclk;

    function automatic placement_t predict_placement(logic cmd, logic [3:0] id,
            logic [15:0] amt [4], logic hl, logic [31:0] sq, logic [15:0] mask);
        placement_t res;
        logic [63:0] sum, best_sum;
        logic found, saw, fits;
        int best;
        res = '0;
        if (cmd == CMD_LOAD) begin
            present[id] = 1'b1;
            healthy[id] = hl;
            notify[id] = sq;
            for (int r = 0; r < 4; r++) free_amt[id][r] = amt[r];
            res.status = ST_LOADED;
            return res;
        end
        found = 1'b0;
        saw = 1'b0;
        best = 0;
        best_sum = '0;
        for (int w = 0; w < NW; w++) begin
            if (!present[w] || !healthy[w]) continue;
            saw = 1'b1;
            if (!mask[w]) continue;
            fits = 1'b1;
            sum = '0;
            for (int r = 0; r < 4; r++) begin
                if (free_amt[w][r] < amt[r]) fits = 1'b0;
                else sum += 64'(free_amt[w][r] - amt[r]) * weight[r];
            end
            if (fits && (!found || sum < best_sum)) begin
                found = 1'b1;
                best = w;
                best_sum = sum;
            end
        end
        if (!found) begin
            res.status = saw ? ST_NOFIT : ST_NOHEALTHY;
            return res;
        end
        for (int r = 0; r < 4; r++) free_amt[best][r] -= amt[r];
        res.status = ST_PLACED;
        res.worker = 4'(best);
        res.seq = notify[best];
        res.leftover = best_sum > 64'h3FFFFFF ? 26'h3FFFFFF : best_sum[25:0];
        return res;
    endfunction

    task automatic send_item(logic cmd, logic [3:0] id, logic [15:0] amt [4],
            logic hl, logic [31:0] sq, logic [15:0] mask);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata <= {2'b00, mask, sq, hl, amt[3], amt[2], amt[1], amt[0], id, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_placement(cmd, id, amt, hl, sq, mask));
    endtask

    task automatic load_worker(int id, logic [15:0] a0, logic [15:0] a1,
            logic [15:0] a2, logic [15:0] a3, logic hl, logic [31:0] sq);
        logic [15:0] amt [4];
        amt = '{a0, a1, a2, a3};
        send_item(CMD_LOAD, 4'(id), amt, hl, sq, 16'($urandom));
    endtask

    task automatic place_task(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
            logic [15:0] a3, logic [15:0] mask);
        logic [15:0] amt [4];
        amt = '{a0, a1, a2, a3};
        send_item(CMD_PLACE, 4'($urandom), amt, 1'($urandom), $urandom, mask);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    task automatic write_weight(int idx, logic [7:0] val);
        cfg_index <= 2'(idx);
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        weight[idx] = val;
    endtask

    task automatic set_weights(logic [7:0] w0, logic [7:0] w1, logic [7:0] w2,
            logic [7:0] w3);
        drain();
        write_weight(0, w0);
        write_weight(1, w1);
        write_weight(2, w2);
        write_weight(3, w3);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        place_task(0, 0, 0, 0, 16'hFFFF);
        load_worker(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFFFFFF);
        place_task(0, 0, 0, 0, 16'hFFFF);
        load_worker(3, 100, 100, 100, 100, 1'b1, 32'h12345678);
        load_worker(7, 50, 50, 50, 50, 1'b1, 32'h0);
        load_worker(15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFFFFFF);
        place_task(10, 10, 10, 10, 16'hFFFF);
        place_task(10, 10, 10, 10, 16'h0000);
        place_task(16'hFFFF, 0, 0, 0, 16'h8000);
        place_task(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        place_task(200, 0, 0, 0, 16'h0088);
        place_task(90, 90, 90, 90, 16'h0008);
        place_task(1, 1, 1, 1, 16'h0008);
        load_worker(7, 50, 50, 50, 50, 1'b0, 32'hA5A5A5A5);
        place_task(0, 0, 0, 0, 16'h0080);
        set_weights(8'd0, 8'd0, 8'd0, 8'd0);
        load_worker(1, 9, 9, 9, 9, 1'b1, 32'h11);
        load_worker(2, 9, 9, 9, 9, 1'b1, 32'h22);
        place_task(1, 2, 3, 4, 16'h0006);
        set_weights(8'd255, 8'd255, 8'd255, 8'd255);
        load_worker(15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 32'hDEAD);
        place_task(0, 0, 0, 0, 16'h8000);
    endtask

    task automatic test_random(int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                load_worker($urandom_range(15), 16'($urandom_range(1000)),
                            16'($urandom_range(1000)), 16'($urandom_range(1000)),
                            16'($urandom_range(1000)), ($urandom_range(9) != 0),
                            $urandom);
            end else if (kind < 34) begin
                load_worker($urandom_range(15), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 1'($urandom), $urandom);
            end else if (kind < 90) begin
                place_task(16'($urandom_range(120)), 16'($urandom_range(120)),
                           16'($urandom_range(120)), 16'($urandom_range(120)),
                           ($urandom_range(3) == 0) ? 16'($urandom) : 16'hFFFF);
            end else begin
                place_task(16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), 16'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        drain();
        hold_off = 200;
        test_random(10);
    endtask

    always @(posedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        placement_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_tdata);
                failed = 1'b1;
            end else begin
                want = expected_q.pop_front();
                if (got.status != want.status || got.worker != want.worker ||
                        got.seq != want.seq || got.leftover != want.leftover) begin
                    $display("%0t: mismatch expected st=%0d w=%0d seq=%h left=%0d",
                             $time, want.status, want.worker, want.seq, want.leftover);
                    $display("%0t:          actual   st=%0d w=%0d seq=%h left=%0d",
                             $time, got.status, got.worker, got.seq, got.leftover);
                    failed = 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < 4; r++) weight[r] = 8'd1;
        for (int w = 0; w < NW; w++) begin
            present[w] = 1'b0;
            healthy[w] = 1'b0;
            notify[w] = '0;
            for (int r = 0; r < 4; r++) free_amt[w][r] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        set_weights(8'd1, 8'd3, 8'd7, 8'd2);
        send_idle_pct = 33;
        recv_idle_pct = 51;
        test_random(550);
        set_weights(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        send_idle_pct = 51;
        recv_idle_pct = 33;
        test_random(550);
        test_backpressure();
        set_weights(8'd255, 8'd0, 8'd128, 8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(520);
        drain();
        if (!failed && expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
